### hdl/tah_pkg.sv
// shared types and constants of the heron triangle area block
package tah_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_W    = 8;
  localparam int SIDE_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W + 1;
  localparam int PER_W     = SIDE_W + 2;
  localparam int FACT_W    = SIDE_W + 1;
  localparam int MA_W      = PER_W + FACT_W;
  localparam int MB_W      = 2 * FACT_W;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int ROOT_W    = (PROD_W + 1) / 2;
  localparam int AREA_W    = 48;
  localparam int LANE_LAT  = 3 + SIDE_W;
  localparam int MERGE_LAT = 7 + ROOT_W;
  localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tah_in_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              degenerate;
  } tah_out_t;

endpackage

### hdl/tah_side_lane.sv
// one side lane: squared distance and pipelined integer square root
module tah_side_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  tah_pkg::vec_t               p_i,
  input  tah_pkg::vec_t               q_i,
  output logic [tah_pkg::SIDE_W-1:0]  side_o
);
  import tah_pkg::*;

  logic [SIDE_W-1:0]   ad_q [3];
  logic [SQ_W-1:0]     sq_q [3];
  logic [2*SIDE_W-1:0] rad_q [SIDE_W];
  logic [SIDE_W+1:0]   rem_q [SIDE_W];
  logic [SIDE_W-1:0]   root_q [SIDE_W+1];

  logic signed [SIDE_W-1:0] d [3];

  always_comb begin
    d[0] = $signed({p_i.x[COORD_W-1], p_i.x}) - $signed({q_i.x[COORD_W-1], q_i.x});
    d[1] = $signed({p_i.y[COORD_W-1], p_i.y}) - $signed({q_i.y[COORD_W-1], q_i.y});
    d[2] = $signed({p_i.z[COORD_W-1], p_i.z}) - $signed({q_i.z[COORD_W-1], q_i.z});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        ad_q[k] <= d[k][SIDE_W-1] ? SIDE_W'(-d[k]) : SIDE_W'(d[k]);
        sq_q[k] <= SQ_W'(ad_q[k] * ad_q[k]);
      end
      rad_q[0]  <= (2*SIDE_W)'(sq_q[0]) + (2*SIDE_W)'(sq_q[1]) + (2*SIDE_W)'(sq_q[2]);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar i = 0; i < SIDE_W; i++) begin : g_step
    logic [SIDE_W+3:0] cur;
    logic [SIDE_W+3:0] trial;
    logic [SIDE_W+3:0] diff;
    logic              ge;

    always_comb begin
      cur   = {rem_q[i], rad_q[i][2*SIDE_W-1 -: 2]};
      trial = {2'b00, root_q[i], 2'b01};
      ge    = cur >= trial;
      diff  = cur - trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i+1] <= {root_q[i][SIDE_W-2:0], ge};
      end
    end

    if (i < SIDE_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[i+1] <= rad_q[i] << 2;
          rem_q[i+1] <= ge ? diff[SIDE_W+1:0] : cur[SIDE_W+1:0];
        end
      end
    end
  end

  assign side_o = root_q[SIDE_W];

endmodule

### hdl/tah_heron_merge.sv
// merging stage: heron factors, split product and pipelined square root
module tah_heron_merge (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tah_pkg::SIDE_W-1:0]  sa_i,
  input  logic [tah_pkg::SIDE_W-1:0]  sb_i,
  input  logic [tah_pkg::SIDE_W-1:0]  sc_i,
  output tah_pkg::tah_out_t           res_o
);
  import tah_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int ALO_W = MA_W - FACT_W;

  logic [PER_W-1:0]   per_q, per2_q;
  logic [SIDE_W-1:0]  s_q [3];
  logic [FACT_W-1:0]  f_q [3];
  logic               deg2_q, deg3_q, deg4_q, deg5_q;
  logic [MA_W-1:0]    ma_q;
  logic [MB_W-1:0]    mb_q;
  logic [ALO_W+FACT_W-1:0] pp_ll_q, pp_lh_q;
  logic [2*FACT_W-1:0]     pp_hl_q, pp_hh_q;
  logic [ALO_W+MB_W-1:0]   s1_q;
  logic [PROD_W-1:0]       s2_q;
  logic [RAD_W-1:0]   rad_q [ROOT_W];
  logic [ROOT_W+1:0]  rem_q [ROOT_W];
  logic [ROOT_W-1:0]  root_q [ROOT_W+1];
  logic               dg_q [ROOT_W+1];
  tah_out_t           res_q;

  logic signed [PER_W:0] fk [3];
  logic                  deg;

  always_comb begin
    deg = (per_q == '0);
    for (int k = 0; k < 3; k++) begin
      fk[k] = $signed({1'b0, per_q}) - $signed({2'b00, s_q[k], 1'b0});
      if (fk[k][PER_W] || fk[k] == '0) deg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      per_q  <= PER_W'(sa_i) + PER_W'(sb_i) + PER_W'(sc_i);
      s_q[0] <= sa_i;
      s_q[1] <= sb_i;
      s_q[2] <= sc_i;
      // a positive factor is below twice the longest side
      for (int k = 0; k < 3; k++) f_q[k] <= fk[k][FACT_W-1:0];
      per2_q <= per_q;
      deg2_q <= deg;
      ma_q   <= MA_W'(per2_q * f_q[0]);
      mb_q   <= MB_W'(f_q[1] * f_q[2]);
      deg3_q <= deg2_q;
      pp_ll_q <= (ALO_W+FACT_W)'(ma_q[ALO_W-1:0] * mb_q[FACT_W-1:0]);
      pp_lh_q <= (ALO_W+FACT_W)'(ma_q[ALO_W-1:0] * mb_q[MB_W-1:FACT_W]);
      pp_hl_q <= (2*FACT_W)'(ma_q[MA_W-1:ALO_W] * mb_q[FACT_W-1:0]);
      pp_hh_q <= (2*FACT_W)'(ma_q[MA_W-1:ALO_W] * mb_q[MB_W-1:FACT_W]);
      deg4_q <= deg3_q;
      s1_q   <= (ALO_W+MB_W)'(pp_ll_q) + ((ALO_W+MB_W)'(pp_lh_q) << FACT_W);
      s2_q   <= (PROD_W'(pp_hl_q) << ALO_W) + (PROD_W'(pp_hh_q) << (ALO_W + FACT_W));
      deg5_q <= deg4_q;
      rad_q[0]  <= RAD_W'(PROD_W'(s1_q) + s2_q);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      dg_q[0]   <= deg5_q;
      res_q.area       <= dg_q[ROOT_W] ? '0
                          : AREA_W'(root_q[ROOT_W] >> (FRAC_W + 2));
      res_q.degenerate <= dg_q[ROOT_W];
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic [ROOT_W+3:0] cur;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              ge;

    always_comb begin
      cur   = {rem_q[i], rad_q[i][RAD_W-1 -: 2]};
      trial = {2'b00, root_q[i], 2'b01};
      ge    = cur >= trial;
      diff  = cur - trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i+1] <= {root_q[i][ROOT_W-2:0], ge};
        dg_q[i+1]   <= dg_q[i];
      end
    end

    if (i < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[i+1] <= rad_q[i] << 2;
          rem_q[i+1] <= ge ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

### hdl/triangle_area_heron_top.sv
// top level of the heron triangle area block: lanes, merge and output skid
//
//  channel  | direction | signals                            | payload
//  request  | in        | in_valid_i, in_stall_o, in_req_i   | tah_in_t, nine coordinates
//  result   | out       | out_valid_o, out_stall_i, out_res_o| tah_out_t, area and flag
//
// one request per cycle while in_stall_o is low; the pipeline depth comes mostly from the
// two bit-per-stage square root pipelines in series (side roots, then area root)
// reset clears the valid bits only; payload registers are left alone
// the pipeline freezes only while the skid register is full; in_stall_o is a flop
module triangle_area_heron_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tah_pkg::tah_in_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tah_pkg::tah_out_t  out_res_o
);
  import tah_pkg::*;

  logic [PIPE_LAT-1:0] vld_q;
  logic                en, accept, take, push;
  logic                out_vld_q, skid_vld_q;
  tah_out_t            out_q, skid_q, res;
  vec_t                va, vb, vc;
  logic [SIDE_W-1:0]   sa, sb, sc;

  assign va = '{x: in_req_i.a_x, y: in_req_i.a_y, z: in_req_i.a_z};
  assign vb = '{x: in_req_i.b_x, y: in_req_i.b_y, z: in_req_i.b_z};
  assign vc = '{x: in_req_i.c_x, y: in_req_i.c_y, z: in_req_i.c_z};

  assign en     = !skid_vld_q;
  assign accept = in_valid_i && !in_stall_o;
  assign take   = out_vld_q && !out_stall_i;
  assign push   = en && vld_q[PIPE_LAT-1];

  tah_side_lane u_lane_a (.clk_i, .en_i(en), .p_i(va), .q_i(vb), .side_o(sa));
  tah_side_lane u_lane_b (.clk_i, .en_i(en), .p_i(vb), .q_i(vc), .side_o(sb));
  tah_side_lane u_lane_c (.clk_i, .en_i(en), .p_i(vc), .q_i(va), .side_o(sc));

  tah_heron_merge u_merge (
    .clk_i,
    .en_i (en),
    .sa_i (sa),
    .sb_i (sb),
    .sc_i (sc),
    .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid filled without a stalled result");

  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[0])
    else $error("accepted request not tracked in the pipeline");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.degenerate) |-> (out_q.area == '0))
    else $error("degenerate result with nonzero area");

endmodule
